@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define BPRU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpru check failed");

// Concurrent check that also runs through reset.
`define BPRU_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bpru check failed");

`endif

@@ src/bpru_pkg.sv @@
// Shared types and constants of the BMP pixel row unpacker.
package bpru_pkg;

   localparam int unsigned CFG_W              = 13;
   localparam int unsigned COORD_W            = 12;
   localparam int unsigned DEFAULT_MAX_WIDTH  = 4096;
   localparam int unsigned DEFAULT_MAX_HEIGHT = 4096;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [2:0] MODE_GRAY = 3'd0;
   localparam logic [2:0] MODE_332  = 3'd1;
   localparam logic [2:0] MODE_1555 = 3'd2;
   localparam logic [2:0] MODE_BGR  = 3'd3;
   localparam logic [2:0] MODE_BGRA = 3'd4;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_PIXEL_MODE   = 2'd2;

   // One decoded word: a full color pixel, or a 1 bpp byte holding up to eight pixels.
   typedef struct packed {
      logic                 is_gray;
      logic [2:0]           count_m1;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [7:0]           blue;
      logic [7:0]           green;
      logic [7:0]           red;
      logic [7:0]           alpha;
      logic                 last_img;
   } entry_type;

endpackage

@@ src/bmp_pixel_row_unpacker_top.sv @@
// BMP pixel row unpacker: takes the bytes of a bottom-up pixel array, one
// byte per word, and sends out one pixel per word with its column and row,
// starting at row height-1. Row padding to four bytes is consumed silently.
// A byte is accepted every cycle while the four-entry queue between the
// decode front and the pixel back end has room. In 8, 16, 24 and 32 bpp
// modes a byte gives at most one pixel, so the block sustains one byte per
// cycle. In 1 bpp mode a byte gives up to eight pixels, issued one per cycle
// by the back end through the single result register while the output is
// taken; bytes back up there. A configuration write restarts the image at row
// height-1 and drops any partly gathered pixel; write only while idle.
module bmp_pixel_row_unpacker_top #(
   parameter int unsigned MAX_WIDTH   = bpru_pkg::DEFAULT_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT  = bpru_pkg::DEFAULT_MAX_HEIGHT,
   parameter int unsigned QUEUE_DEPTH = bpru_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [11:0]                rsp_pixel_x,
   output logic [11:0]                rsp_pixel_y,
   output logic [7:0]                 rsp_blue,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_alpha,
   output logic                       rsp_last_of_byte,
   output logic                       rsp_last_of_image,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [bpru_pkg::CFG_W-1:0] csr_data
);

   logic                q_push, q_ready, q_valid, q_pop;
   bpru_pkg::entry_type q_entry, q_head;

   bpru_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_ready       (q_ready),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   bpru_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .head_valid (q_valid),
      .head_entry (q_head),
      .pop        (q_pop)
   );

   bpru_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_blue          (rsp_blue),
      .rsp_green         (rsp_green),
      .rsp_red           (rsp_red),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule

@@ src/bpru_front.sv @@
// Front end: configuration, row bookkeeping, pixel assembly and color scaling.
module bpru_front #(
   parameter int unsigned MAX_WIDTH  = bpru_pkg::DEFAULT_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = bpru_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [bpru_pkg::CFG_W-1:0]    csr_data,
   input  logic                          q_ready,
   output logic                          q_push,
   output bpru_pkg::entry_type           q_entry
);

   localparam int unsigned CFG_MAX = (1 << bpru_pkg::CFG_W) - 1;
   localparam int unsigned WCAP = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
   localparam int unsigned HCAP = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;

   // floor(v*255/7), floor(v*255/3), floor(v*255/31) by reciprocal multiply
   function automatic logic [7:0] scale3(input logic [2:0] v);
      logic [31:0] p;
      p = 32'(v) * 32'd255 * 32'd9363;
      return p[23:16];
   endfunction

   function automatic logic [7:0] scale2(input logic [1:0] v);
      logic [31:0] p;
      p = 32'(v) * 32'd255 * 32'd21846;
      return p[23:16];
   endfunction

   function automatic logic [7:0] scale5(input logic [4:0] v);
      logic [31:0] p;
      p = 32'(v) * 32'd255 * 32'd33826;
      return p[27:20];
   endfunction

   logic [12:0] width_ff, height_ff;
   logic [2:0]  mode_ff;
   logic [12:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic [1:0]  bip_ff, bip_in;
   logic [23:0] part_ff, part_in;
   logic [14:0] rbc_ff, rbc_in;
   logic        start_ff, start_in;

   logic [12:0] w_eff, h_eff, h_last, row_cur, rem;
   logic [2:0]  mode_eff;
   logic [1:0]  need_m1;
   logic [15:0] stride;
   logic        accept, restart, in_row, row_end, pix_done, ends, produce;
   logic [2:0]  n_m1;
   logic [23:0] part_new;
   logic [7:0]  d;
   bpru_pkg::entry_type entry;

   assign csr_ready = 1'b1;
   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;
   assign restart   = csr_valid && (csr_index == bpru_pkg::REG_IMAGE_WIDTH ||
                      csr_index == bpru_pkg::REG_IMAGE_HEIGHT ||
                      csr_index == bpru_pkg::REG_PIXEL_MODE);
   assign d         = req_data_byte;

   always_comb begin
      if (width_ff == 13'd0) begin
         w_eff = 13'd1;
      end else if (width_ff > 13'(WCAP)) begin
         w_eff = 13'(WCAP);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (height_ff > 13'(HCAP)) begin
         h_eff = 13'(HCAP);
      end else begin
         h_eff = height_ff;
      end
      h_last   = h_eff - 13'd1;
      mode_eff = (mode_ff > bpru_pkg::MODE_BGRA) ? bpru_pkg::MODE_BGR : mode_ff;
   end

   // row stride in bytes, padded to 4
   always_comb begin
      unique case (mode_eff)
         bpru_pkg::MODE_GRAY: begin
            stride  = ((16'(w_eff) + 16'd31) >> 5) << 2;
            need_m1 = 2'd0;
         end
         bpru_pkg::MODE_332: begin
            stride  = ((16'(w_eff) + 16'd3) >> 2) << 2;
            need_m1 = 2'd0;
         end
         bpru_pkg::MODE_1555: begin
            stride  = ((16'(w_eff) + 16'd1) >> 1) << 2;
            need_m1 = 2'd1;
         end
         bpru_pkg::MODE_BGRA: begin
            stride  = 16'(w_eff) << 2;
            need_m1 = 2'd3;
         end
         default: begin
            stride  = (((16'(w_eff) << 1) + 16'(w_eff) + 16'd3) >> 2) << 2;
            need_m1 = 2'd2;
         end
      endcase
   end

   always_comb begin
      row_cur  = start_ff ? h_last : row_ff;
      in_row   = col_ff < w_eff;
      rem      = w_eff - col_ff;
      if (rem >= 13'd8) begin
         n_m1 = 3'd7;
         ends = (rem == 13'd8);
      end else begin
         n_m1 = rem[2:0] - 3'd1;
         ends = 1'b1;
      end
      part_new = part_ff | (24'(d) << {bip_ff, 3'b000});
      pix_done = bip_ff >= need_m1;
      row_end  = (16'(rbc_ff) + 16'd1) >= stride;

      entry          = '0;
      entry.x        = col_ff[11:0];
      entry.y        = row_cur[11:0];
      entry.alpha    = 8'hFF;
      entry.last_img = (row_cur == 13'd0) && (col_ff == w_eff - 13'd1);
      unique case (mode_eff)
         bpru_pkg::MODE_GRAY: begin
            entry.is_gray  = 1'b1;
            entry.count_m1 = n_m1;
            entry.blue     = d;
            entry.last_img = (row_cur == 13'd0) && ends;
         end
         bpru_pkg::MODE_332: begin
            entry.blue  = scale2(d[1:0]);
            entry.green = scale3(d[4:2]);
            entry.red   = scale3(d[7:5]);
         end
         bpru_pkg::MODE_1555: begin
            entry.blue  = scale5(part_new[4:0]);
            entry.green = scale5(part_new[9:5]);
            entry.red   = scale5(part_new[14:10]);
            entry.alpha = part_new[15] ? 8'hFF : 8'h00;
         end
         bpru_pkg::MODE_BGRA: begin
            entry.blue  = part_new[7:0];
            entry.green = part_new[15:8];
            entry.red   = part_new[23:16];
            entry.alpha = d;
         end
         default: begin
            entry.blue  = part_new[7:0];
            entry.green = part_new[15:8];
            entry.red   = part_new[23:16];
         end
      endcase
      produce = in_row && ((mode_eff == bpru_pkg::MODE_GRAY) || pix_done);
   end

   assign q_push  = accept && produce;
   assign q_entry = entry;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      bip_in   = bip_ff;
      part_in  = part_ff;
      rbc_in   = rbc_ff;
      start_in = start_ff;
      if (restart) begin
         col_in   = '0;
         bip_in   = '0;
         part_in  = '0;
         rbc_in   = '0;
         start_in = 1'b1;
      end else if (accept) begin
         if (in_row) begin
            if (mode_eff == bpru_pkg::MODE_GRAY) begin
               col_in = col_ff + 13'(n_m1) + 13'd1;
            end else if (pix_done) begin
               col_in  = col_ff + 13'd1;
               bip_in  = '0;
               part_in = '0;
            end else begin
               bip_in  = bip_ff + 2'd1;
               part_in = part_new;
            end
         end
         start_in = 1'b0;
         if (row_end) begin
            rbc_in  = '0;
            col_in  = '0;
            bip_in  = '0;
            part_in = '0;
            row_in  = (row_cur == 13'd0) ? h_last : row_cur - 13'd1;
         end else begin
            rbc_in = rbc_ff + 15'd1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         mode_ff   <= bpru_pkg::MODE_BGR;
         col_ff    <= '0;
         bip_ff    <= '0;
         part_ff   <= '0;
         rbc_ff    <= '0;
         start_ff  <= 1'b1;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               bpru_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data;
               bpru_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
               bpru_pkg::REG_PIXEL_MODE:   mode_ff   <= csr_data[2:0];
               default: ;
            endcase
         end
         col_ff   <= col_in;
         bip_ff   <= bip_in;
         part_ff  <= part_in;
         rbc_ff   <= rbc_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

endmodule

@@ src/bpru_queue.sv @@
// Short word queue between the decode front and the pixel back end.
module bpru_queue #(
   parameter int unsigned DEPTH = bpru_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bpru_pkg::entry_type push_entry,
   output logic                push_ready,
   output logic                head_valid,
   output bpru_pkg::entry_type head_entry,
   input  logic                pop
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   bpru_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/bpru_back.sv @@
// Back end: expands queued words into pixels and holds the output register.
module bpru_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  bpru_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [11:0]         rsp_pixel_x,
   output logic [11:0]         rsp_pixel_y,
   output logic [7:0]          rsp_blue,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_alpha,
   output logic                rsp_last_of_byte,
   output logic                rsp_last_of_image
);

   logic [2:0]  k_ff, k_in;
   logic        valid_ff, valid_in;
   logic [11:0] x_ff, y_ff;
   logic [7:0]  blue_ff, green_ff, red_ff, alpha_ff;
   logic        lob_ff, loi_ff;
   logic        load, last_k;
   logic [7:0]  gray;

   assign load   = q_valid && (!valid_ff || rsp_ready);
   assign last_k = k_ff == q_head.count_m1;
   assign q_pop  = load && last_k;
   assign gray   = q_head.blue[3'd7 - k_ff] ? 8'hFF : 8'h00;

   always_comb begin
      k_in = k_ff;
      if (load) begin
         k_in = last_k ? 3'd0 : k_ff + 3'd1;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff   <= q_head.x + 12'(k_ff);
         y_ff   <= q_head.y;
         lob_ff <= last_k;
         loi_ff <= last_k && q_head.last_img;
         if (q_head.is_gray) begin
            blue_ff  <= gray;
            green_ff <= gray;
            red_ff   <= gray;
            alpha_ff <= 8'hFF;
         end else begin
            blue_ff  <= q_head.blue;
            green_ff <= q_head.green;
            red_ff   <= q_head.red;
            alpha_ff <= q_head.alpha;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_x       = x_ff;
   assign rsp_pixel_y       = y_ff;
   assign rsp_blue          = blue_ff;
   assign rsp_green         = green_ff;
   assign rsp_red           = red_ff;
   assign rsp_alpha         = alpha_ff;
   assign rsp_last_of_byte  = lob_ff;
   assign rsp_last_of_image = loi_ff;

endmodule

@@ src/bpru_checker.sv @@
// Port-level checker for the BMP pixel row unpacker, bound to the top level.
`include "assert_macros.svh"

module bpru_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [11:0]                rsp_pixel_x,
   input logic [11:0]                rsp_pixel_y,
   input logic [7:0]                 rsp_blue,
   input logic [7:0]                 rsp_green,
   input logic [7:0]                 rsp_red,
   input logic [7:0]                 rsp_alpha,
   input logic                       rsp_last_of_byte,
   input logic                       rsp_last_of_image
);

   logic [57:0] rsp_word;

   assign rsp_word = {rsp_pixel_x, rsp_pixel_y, rsp_blue, rsp_green, rsp_red, rsp_alpha,
                      rsp_last_of_byte, rsp_last_of_image};

   // stalled word holds
   `BPRU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))

   // image end falls on the last pixel of a byte in row zero
   `BPRU_ASSERT(a_last_image, clock, reset, rsp_valid && rsp_last_of_image |-> rsp_last_of_byte && rsp_pixel_y == 12'd0)

   // pixels of one byte leave back to back on adjacent columns
   `BPRU_ASSERT(a_byte_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_byte |=> rsp_valid && rsp_pixel_x == $past(rsp_pixel_x) + 12'd1 && rsp_pixel_y == $past(rsp_pixel_y))

   `BPRU_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind bmp_pixel_row_unpacker_top bpru_checker u_bpru_checker (.*);
